[design/assert_macros.svh]
// Assertion macros shared by the decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked property with the reset cycles masked.
`define SBFD_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property that also covers the reset cycles.
`define SBFD_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SBFD_ASSERT(name, clk, rst, prop, msg)
`define SBFD_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

[design/sbfd_pkg.sv]
// Types, codes and constants of the serial frame decoder.
`timescale 1ns / 1ps
package sbfd_pkg;

  localparam int FRAME_LEN        = 25;
  localparam int DEF_NUM_CHANNELS = 16;
  localparam int MODE_W           = 2;
  localparam int BYTE_W           = 8;
  localparam int RAW_W            = 11;
  localparam int NORM_W           = 16;
  localparam int AGE_W            = 16;
  localparam int CFG_DATA_W       = 16;
  localparam int COUNT_W          = 5;
  localparam int CH_W             = 4;
  localparam int BUF_W            = FRAME_LEN * BYTE_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX     = 5'd31;
  localparam logic [BYTE_W-1:0]  START_BYTE    = 8'h0F;
  localparam logic [RAW_W-1:0]   CENTER_RESET  = 11'd1024;
  localparam logic [AGE_W-1:0]   TIMEOUT_RESET = 16'd100;
  localparam logic [AGE_W-1:0]   AGE_MAX       = 16'hFFFF;

  // Scaling by 16384/671: numerator is mag * 2^14 plus half the divisor,
  // and the divide is a multiply by ceil(2^35 / 671) followed by a shift.
  localparam int NUM_W       = RAW_W + 14;
  localparam int RECIP_W     = 26;
  localparam int PROD_W      = NUM_W + RECIP_W;
  localparam int RECIP_SHIFT = 35;
  localparam logic [NUM_W-1:0]   ROUND_BIAS = 25'd335;
  localparam logic [RECIP_W-1:0] RECIP_MULT = 26'd51206764;

  typedef enum logic [MODE_W-1:0] {
    MODE_BYTE = 2'd0,
    MODE_IDLE = 2'd1,
    MODE_TICK = 2'd2
  } mode_t;

  typedef enum logic {
    CFG_CENTER  = 1'b0,
    CFG_TIMEOUT = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CH_PREP,
    ST_CH_MUL,
    ST_CH_LOAD,
    ST_STATUS
  } state_t;

  typedef struct packed {
    logic accept;
    logic ch_prep;
    logic ch_mul;
    logic ch_load;
    logic st_load;
  } dp_cmd_t;

  typedef struct packed {
    logic frame_good;
    logic tick_offline;
    logic out_free;
    logic last_channel;
  } dp_sts_t;

endpackage

[design/sbfd_datapath.sv]
// Datapath: frame buffer, age counter, channel unpack and scaling, result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sbfd_datapath
  import sbfd_pkg::*;
#(
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic                     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic [MODE_W-1:0]        mode,
  input  logic [BYTE_W-1:0]        data_byte,
  input  dp_cmd_t                  cmd,
  output dp_sts_t                  sts,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic                     is_channel,
  output logic [CH_W-1:0]          channel_index,
  output logic [RAW_W-1:0]         raw_value,
  output logic signed [NORM_W-1:0] normalized,
  output logic                     online,
  output logic                     last
);

  localparam int STREAM_LO = BYTE_W;

  logic [RAW_W-1:0]   center;
  logic [AGE_W-1:0]   timeout_ms;
  logic [COUNT_W-1:0] byte_count;
  logic [AGE_W-1:0]   age_ms;
  logic [BUF_W-1:0]   frame_buf;
  logic [CH_W-1:0]    ch;
  logic [RAW_W-1:0]   raw_q;
  logic               neg_q;
  logic [NUM_W-1:0]   num_q;
  logic [PROD_W-1:0]  prod_q;

  logic               complete;
  logic signed [RAW_W:0] diff;
  logic [RAW_W-1:0]   mag;
  logic [NORM_W-1:0]  quot;
  logic [NORM_W-1:0]  norm_next;

  assign complete = (byte_count == COUNT_W'(FRAME_LEN));

  assign sts.frame_good   = (mode_t'(mode) == MODE_IDLE) && complete &&
                            (frame_buf[BYTE_W-1:0] == START_BYTE);
  // The tick crosses the limit exactly when the age sits at the limit and can still grow.
  assign sts.tick_offline = (mode_t'(mode) == MODE_TICK) && (age_ms == timeout_ms) &&
                            (age_ms != AGE_MAX);
  assign sts.out_free     = !out_valid || out_ready;
  assign sts.last_channel = (ch == CH_W'(NUM_CHANNELS - 1));

  assign diff = $signed({1'b0, frame_buf[STREAM_LO +: RAW_W]}) - $signed({1'b0, center});
  assign mag  = diff[RAW_W] ? RAW_W'(-diff) : diff[RAW_W-1:0];
  assign quot = prod_q[RECIP_SHIFT +: NORM_W];

  always_comb begin
    if (neg_q) begin
      norm_next = quot[NORM_W-1] ? {1'b1, {(NORM_W-1){1'b0}}} : (~quot + 1'b1);
    end else begin
      norm_next = quot[NORM_W-1] ? {1'b0, {(NORM_W-1){1'b1}}} : quot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      center     <= CENTER_RESET;
      timeout_ms <= TIMEOUT_RESET;
    end else if (cfg_write) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CENTER:  center     <= cfg_data[RAW_W-1:0];
        CFG_TIMEOUT: timeout_ms <= cfg_data[AGE_W-1:0];
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      age_ms     <= '0;
      ch         <= '0;
    end else if (cmd.accept) begin
      ch <= '0;
      case (mode_t'(mode))
        MODE_BYTE: begin
          if (byte_count != COUNT_MAX) byte_count <= byte_count + 1'b1;
        end
        MODE_IDLE: begin
          byte_count <= '0;
          if (complete) age_ms <= '0;
        end
        MODE_TICK: begin
          if (age_ms != AGE_MAX) age_ms <= age_ms + 1'b1;
        end
        default: ;
      endcase
    end else if (cmd.ch_load) begin
      ch <= ch + 1'b1;
    end
  end

  // Bytes shift in from the top, so after a full frame byte 0 sits at the bottom and
  // the channel stream runs LSB-first above it. Emission shifts the stream down.
  always_ff @(posedge clk) begin
    if (cmd.accept && mode_t'(mode) == MODE_BYTE && byte_count < COUNT_W'(FRAME_LEN)) begin
      frame_buf <= {data_byte, frame_buf[BUF_W-1:BYTE_W]};
    end else if (cmd.ch_load) begin
      frame_buf <= {{RAW_W{1'b0}}, frame_buf[BUF_W-1:STREAM_LO+RAW_W],
                    frame_buf[STREAM_LO-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ch_prep) begin
      raw_q <= frame_buf[STREAM_LO +: RAW_W];
      neg_q <= diff[RAW_W];
      num_q <= {mag, 14'b0} + ROUND_BIAS;
    end
    if (cmd.ch_mul) begin
      prod_q <= PROD_W'(num_q) * PROD_W'(RECIP_MULT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.ch_load || cmd.st_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ch_load) begin
      is_channel    <= 1'b1;
      channel_index <= ch;
      raw_value     <= raw_q;
      normalized    <= norm_next;
      online        <= 1'b1;
      last          <= sts.last_channel;
    end else if (cmd.st_load) begin
      is_channel    <= 1'b0;
      channel_index <= '0;
      raw_value     <= '0;
      normalized    <= '0;
      online        <= 1'b0;
      last          <= 1'b1;
    end
  end

  `SBFD_ASSERT(a_load_slot_free, clk, rst, (cmd.ch_load || cmd.st_load) |-> sts.out_free, "result loaded over a pending beat")
  `SBFD_ASSERT(a_ch_beat, clk, rst, cmd.ch_load |=> (out_valid && is_channel && online), "channel load did not present a channel beat")
  `SBFD_ASSERT(a_status_beat, clk, rst, cmd.st_load |=> (out_valid && !is_channel && last && !online), "status load did not present an offline beat")
  `SBFD_ASSERT(a_last_ch, clk, rst, (cmd.ch_load && sts.last_channel) |=> last, "final channel beat not marked last")

endmodule

[design/sbfd_ctrl.sv]
// Controller: sequences input acceptance and the per-channel prep, multiply and load steps.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sbfd_ctrl
  import sbfd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && sts.frame_good) begin
          state_next = ST_CH_PREP;
        end else if (in_valid && sts.tick_offline) begin
          state_next = ST_STATUS;
        end
      end
      ST_CH_PREP: begin
        cmd.ch_prep = 1'b1;
        state_next  = ST_CH_MUL;
      end
      ST_CH_MUL: begin
        cmd.ch_mul = 1'b1;
        state_next = ST_CH_LOAD;
      end
      ST_CH_LOAD: begin
        if (sts.out_free) begin
          cmd.ch_load = 1'b1;
          state_next  = sts.last_channel ? ST_IDLE : ST_CH_PREP;
        end
      end
      ST_STATUS: begin
        if (sts.out_free) begin
          cmd.st_load = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `SBFD_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> (state == ST_IDLE), "controller not idle after reset")
  `SBFD_ASSERT(a_burst_ends, clk, rst, (cmd.ch_load && sts.last_channel) |=> in_ready, "input not reopened after final channel")
  `SBFD_ASSERT(a_status_ends, clk, rst, cmd.st_load |=> in_ready, "input not reopened after status beat")

endmodule

[design/sbus_frame_decoder.sv]
// Top level of the 16-channel serial receiver frame decoder.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-------------------------------------------
//   in       | sink      | in_valid / in_ready  | mode, data_byte
//   out      | source    | out_valid / out_ready| is_channel, channel_index, raw_value,
//            |           |                      | normalized, online, last
//   cfg      | sink      | cfg_write            | cfg_index, cfg_data
//
// A byte, a short idle event or a tick without offline crossing is handled on accept.
// A good frame end leads into the prep, multiply and load steps for each channel in
// turn, through the single reciprocal multiplier; a load waits out any out stall. An
// offline tick leads into a status load, which also waits out any stall. The result
// register lets a new beat be accepted while the last result still waits on out_ready.
// Reset is synchronous; it restores the register defaults and clears counters.
`timescale 1ns / 1ps
module sbus_frame_decoder
  import sbfd_pkg::*;
#(
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic                     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [MODE_W-1:0]        mode,
  input  logic [BYTE_W-1:0]        data_byte,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     is_channel,
  output logic [CH_W-1:0]          channel_index,
  output logic [RAW_W-1:0]         raw_value,
  output logic signed [NORM_W-1:0] normalized,
  output logic                     online,
  output logic                     last
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  sbfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sbfd_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mode          (mode),
    .data_byte     (data_byte),
    .cmd           (cmd),
    .sts           (sts),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .is_channel    (is_channel),
    .channel_index (channel_index),
    .raw_value     (raw_value),
    .normalized    (normalized),
    .online        (online),
    .last          (last)
  );

endmodule

[tb/sv/sbus_frame_decoder_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the serial frame decoder, with random traffic and predicted results.
module sbus_frame_decoder_test;
  import sbfd_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int Q14_ONE        = 16384;
  localparam int STICK_DIV      = 671;
  localparam int SETTLE_CYCLES  = 64;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_REPORTS    = 30;

  typedef struct {
    logic [MODE_W-1:0] ev_mode;
    logic [BYTE_W-1:0] ev_byte;
  } rx_event_t;

  typedef struct {
    logic                     is_ch;
    logic [CH_W-1:0]          ch;
    logic [RAW_W-1:0]         raw;
    logic signed [NORM_W-1:0] norm;
    logic                     on;
    logic                     lst;
  } decoded_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_write = 1'b0;
  logic                     cfg_index = 1'b0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [MODE_W-1:0]        mode = '0;
  logic [BYTE_W-1:0]        data_byte = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     is_channel;
  logic [CH_W-1:0]          channel_index;
  logic [RAW_W-1:0]         raw_value;
  logic signed [NORM_W-1:0] normalized;
  logic                     online;
  logic                     last;

  // Shadow of the decoder state and its registers.
  logic [RAW_W-1:0]   center_r = CENTER_RESET;
  logic [AGE_W-1:0]   timeout_r = TIMEOUT_RESET;
  logic [COUNT_W-1:0] rx_count = '0;
  logic [BYTE_W-1:0]  rx_bytes [FRAME_LEN];
  logic [AGE_W-1:0]   link_age = '0;

  rx_event_t pending_events[$];
  decoded_t  expected_results[$];

  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic hold_start = 1'b0;
  int   hold_left = 0;
  int   quiet_cycles = 0;

  int mismatches = 0;
  int beats_in = 0;
  int beats_out = 0;
  int frames_decoded = 0;
  int offline_notices = 0;
  int settings_used = 1;

  sbus_frame_decoder DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .data_byte     (data_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .is_channel    (is_channel),
    .channel_index (channel_index),
    .raw_value     (raw_value),
    .normalized    (normalized),
    .online        (online),
    .last          (last)
  );

  always #5 clk = ~clk;

  // Stick position to Q1.14, rounded half away from zero, then clamped to 16 bits.
  function automatic logic signed [NORM_W-1:0] scale_q14(input logic [RAW_W-1:0] raw);
    int diff;
    int mag;
    int q;
    diff = int'(raw) - int'(center_r);
    mag = (diff < 0) ? -diff : diff;
    q = (mag * Q14_ONE + STICK_DIV / 2) / STICK_DIV;
    if (diff < 0) q = -q;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return NORM_W'(q);
  endfunction

  task automatic predict_event(input logic [MODE_W-1:0] m, input logic [BYTE_W-1:0] d);
    decoded_t         r;
    int               bitpos;
    int               base;
    logic [23:0]      word;
    logic [AGE_W-1:0] prev_age;
    if (m == MODE_BYTE) begin
      if (rx_count < FRAME_LEN) rx_bytes[rx_count] = d;
      if (rx_count != COUNT_MAX) rx_count++;
    end else if (m == MODE_IDLE) begin
      if (rx_count == FRAME_LEN) begin
        link_age = '0;
        if (rx_bytes[0] == START_BYTE) begin
          frames_decoded++;
          for (int ch = 0; ch < DEF_NUM_CHANNELS; ch++) begin
            // Channels are packed LSB first starting at byte 1.
            bitpos = ch * RAW_W;
            base = 1 + bitpos / 8;
            word = {rx_bytes[base + 2], rx_bytes[base + 1], rx_bytes[base]};
            r.is_ch = 1'b1;
            r.ch = CH_W'(ch);
            r.raw = RAW_W'(word >> (bitpos % 8));
            r.norm = scale_q14(r.raw);
            r.on = 1'b1;
            r.lst = (ch == DEF_NUM_CHANNELS - 1);
            expected_results.push_back(r);
          end
        end
      end
      rx_count = '0;
    end else if (m == MODE_TICK) begin
      prev_age = link_age;
      if (link_age != AGE_MAX) link_age++;
      // Only the tick that crosses the timeout raises the notice.
      if (prev_age <= timeout_r && link_age > timeout_r) begin
        offline_notices++;
        r.is_ch = 1'b0;
        r.ch = '0;
        r.raw = '0;
        r.norm = '0;
        r.on = 1'b0;
        r.lst = 1'b1;
        expected_results.push_back(r);
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                 input logic signed [31:0] want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0d ns: mismatch on %s: got %0d, expected %0d (result beat %0d)",
               $time, what, got, want, beats_out);
  endtask

  task automatic push_event(input logic [MODE_W-1:0] m, input logic [BYTE_W-1:0] d);
    rx_event_t e;
    e.ev_mode = m;
    e.ev_byte = d;
    pending_events.push_back(e);
  endtask

  task automatic push_frame(input logic [BYTE_W-1:0] head, input int len);
    for (int i = 0; i < len; i++)
      push_event(MODE_BYTE, (i == 0) ? head : BYTE_W'($urandom_range(255)));
    push_event(MODE_IDLE, BYTE_W'($urandom));
  endtask

  // Mostly well-formed frames, mixed with bad frames, tick runs and unused codes.
  task automatic push_traffic(input int budget);
    int               start_size;
    int               pick;
    logic [BYTE_W-1:0] head;
    start_size = pending_events.size();
    while (pending_events.size() - start_size < budget) begin
      pick = $urandom_range(99);
      head = BYTE_W'($urandom_range(255));
      if (pick < 45) begin
        push_frame(START_BYTE, FRAME_LEN);
      end else if (pick < 53) begin
        if (head == START_BYTE) head = ~head;
        push_frame(head, FRAME_LEN);
      end else if (pick < 63) begin
        push_frame(head, $urandom_range(FRAME_LEN - 1));
      end else if (pick < 70) begin
        push_frame(head, $urandom_range(36, FRAME_LEN + 1));
      end else if (pick < 95) begin
        repeat ($urandom_range(8, 1)) push_event(MODE_TICK, BYTE_W'($urandom));
      end else begin
        push_event(MODE_UNUSED, BYTE_W'($urandom));
      end
    end
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_CENTER) center_r = value[RAW_W-1:0];
    else timeout_r = value;
  endtask

  // Wait until every beat is in and every result is out, then let the block settle.
  task automatic drain();
    do @(negedge clk);
    while (pending_events.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic start_phase(input logic [RAW_W-1:0] c, input logic [AGE_W-1:0] t,
                             input int idle_pct, input int stall_pct);
    drain();
    write_reg(CFG_CENTER, CFG_DATA_W'(c));
    write_reg(CFG_TIMEOUT, t);
    send_idle_pct <= idle_pct;
    recv_stall_pct <= stall_pct;
    settings_used++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin : driver
    logic      busy;
    rx_event_t beat;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        predict_event(mode, data_byte);
        beats_in++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          beat = pending_events.pop_front();
          in_valid <= 1'b1;
          mode <= beat.ev_mode;
          data_byte <= beat.ev_byte;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    decoded_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        beats_out++;
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with nothing expected", 0, 0);
        end else begin
          want = expected_results.pop_front();
          if (is_channel !== want.is_ch)
            report_mismatch("is_channel", is_channel, want.is_ch);
          if (channel_index !== want.ch)
            report_mismatch("channel_index", channel_index, want.ch);
          if (raw_value !== want.raw)
            report_mismatch("raw_value", raw_value, want.raw);
          if (normalized !== want.norm)
            report_mismatch("normalized", normalized, want.norm);
          if (online !== want.on)
            report_mismatch("online", online, want.on);
          if (last !== want.lst)
            report_mismatch("last", last, want.lst);
        end
      end
      out_ready <= (hold_left == 0) && !hold_start && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off, so the decoder backs up into its input.
  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (hold_start) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("No beat moved for %0d cycles, %0d results still expected.",
               WATCHDOG_LIMIT, expected_results.size());
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Unused code, idle with nothing received, a short frame, then a frame whose
    // lower channels are all zeros and upper channels all ones.
    push_event(MODE_UNUSED, 8'hFF);
    push_event(MODE_UNUSED, 8'h00);
    push_event(MODE_IDLE, 8'h5A);
    push_event(MODE_TICK, 8'hA5);
    push_event(MODE_BYTE, START_BYTE);
    push_event(MODE_BYTE, 8'hFF);
    push_event(MODE_BYTE, 8'h00);
    push_event(MODE_IDLE, 8'hFF);
    push_event(MODE_BYTE, START_BYTE);
    for (int i = 1; i < FRAME_LEN; i++) push_event(MODE_BYTE, (i < 12) ? 8'h00 : 8'hFF);
    push_event(MODE_IDLE, 8'h00);
    push_event(MODE_TICK, 8'hFF);
    push_traffic(40);

    start_phase(11'd0, 16'd0, 49, 0);
    push_traffic(70);
    start_phase(11'd2047, 16'hFFFF, 0, 49);
    push_traffic(70);
    start_phase(RAW_W'($urandom_range(2047)), 16'd3, 17, 17);
    push_traffic(70);

    start_phase(CENTER_RESET, 16'd5, 0, 0);
    repeat (3) push_frame(START_BYTE, FRAME_LEN);
    repeat (8) push_event(MODE_TICK, BYTE_W'($urandom));
    @(posedge clk);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;

    drain();
    $display("Run covered %0d input beats and %0d result beats over %0d register settings.",
             beats_in, beats_out, settings_used);
    $display("%0d frames decoded into channels, %0d offline notices, %0d mismatches.",
             frames_decoded, offline_notices, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
